// File: rtl/pas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types and constants of the priority aging scheduler.
// ----------------------------------------------------------------------------
package pas_pkg;
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_FORK     = 3'd1;
    localparam logic [2:0] CMD_EXEC     = 3'd2;
    localparam logic [2:0] CMD_EXIT     = 3'd3;
    localparam logic [2:0] CMD_KILL     = 3'd4;
    localparam logic [2:0] CMD_KILL_ALL = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [7:0]  IDLE_PRIORITY       = 8'd2;
    localparam logic [15:0] FORK_PRIORITY_RESET = 16'd100;

    typedef struct packed {
        logic start;   // load command, clear scan
        logic age;     // aging pass step
        logic pick;    // selection pass step
        logic finish;  // apply tick result / non-tick command
    } t_ctl;

    typedef struct packed {
        logic last;    // scan at final slot
    } t_sts;
endpackage
`default_nettype wire

// File: rtl/pas_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_datapath
// Slot table, scan counter and per-command update logic.
// ----------------------------------------------------------------------------
module pas_datapath #(
    parameter int SLOTS     = 16,
    parameter int AGE_WIDTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  pas_pkg::t_ctl     i_ctl,
    output pas_pkg::t_sts     o_sts,
    input  wire               i_cfg_we,
    input  wire [15:0]        i_cfg_data,
    input  wire [2:0]         i_cmd,
    input  wire [3:0]         i_target_pid,
    input  wire [7:0]         i_new_priority,
    input  wire               i_exit_failed,
    output logic [3:0]        o_active_pid,
    output logic [3:0]        o_parent_pid,
    output logic [3:0]        o_forked_pid,
    output logic [1:0]        o_status
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AGE_WIDTH:0] AGE_MAX = {1'b0, {AGE_WIDTH{1'b1}}};

    logic [SLOTS-1:0]     r_run, r_asg;
    logic [7:0]           r_base [SLOTS];
    logic [AGE_WIDTH-1:0] r_aged [SLOTS];
    logic [IW-1:0]        r_par  [SLOTS];
    logic [IW-1:0]        r_cur;
    logic [15:0]          r_fprio;
    logic [2:0]           r_cmd;
    logic [3:0]           r_tgt;
    logic [7:0]           r_newp;
    logic                 r_fail;
    logic [IW-1:0]        r_idx, r_best;
    logic [AGE_WIDTH-1:0] r_best_age;

    logic [AGE_WIDTH-1:0] w_fp, w_aged_idx;
    logic [AGE_WIDTH:0]   w_sum;
    logic [IW-1:0]        w_free;
    logic [IW-1:0]        w_tgt_idx;
    logic                 w_any_free, w_tgt_ok;

    assign o_sts.last = (r_idx == IW'(SLOTS - 1));

    always_comb begin
        w_free = '0;
        w_any_free = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_run[k]) begin
                w_free = IW'(k);
                w_any_free = 1'b1;
            end
        end
        w_fp = (AGE_WIDTH >= 16) ? AGE_WIDTH'(r_fprio)
             : ((r_fprio > 16'(AGE_MAX)) ? AGE_MAX[AGE_WIDTH-1:0] : AGE_WIDTH'(r_fprio));
        w_aged_idx = r_aged[r_idx];
        w_sum = {1'b0, w_aged_idx} + (AGE_WIDTH+1)'(r_base[r_idx]);
        w_tgt_idx = IW'(r_tgt);
        if (r_tgt == 4'd0) w_tgt_ok = 1'b1;
        else if (32'(r_tgt) < SLOTS) w_tgt_ok = r_asg[w_tgt_idx];
        else w_tgt_ok = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fprio <= pas_pkg::FORK_PRIORITY_RESET;
        end else if (i_cfg_we) begin
            r_fprio <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= SLOTS'(1);
            r_asg <= '0;
            r_cur <= '0;
            r_idx <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_base[k] <= (k == 0) ? pas_pkg::IDLE_PRIORITY : 8'd0;
                r_aged[k] <= (k == 0) ? AGE_WIDTH'(pas_pkg::IDLE_PRIORITY) : '0;
                r_par[k]  <= '0;
            end
        end else begin
            if (i_ctl.start) begin
                r_cmd  <= i_cmd;
                r_tgt  <= i_target_pid;
                r_newp <= i_new_priority;
                r_fail <= i_exit_failed;
                r_idx  <= '0;
                r_best <= '0;
                r_best_age <= '0;
            end
            if (i_ctl.age) begin
                if (r_idx == r_cur) begin
                    r_aged[r_idx] <= AGE_WIDTH'(r_base[r_idx]);
                end else if (r_run[r_idx]) begin
                    r_aged[r_idx] <= (w_sum > AGE_MAX) ? AGE_MAX[AGE_WIDTH-1:0]
                                                       : w_sum[AGE_WIDTH-1:0];
                end
                r_idx <= o_sts.last ? '0 : r_idx + 1'b1;
            end
            if (i_ctl.pick) begin
                if (r_run[r_idx] && w_aged_idx > r_best_age) begin
                    r_best <= r_idx;
                    r_best_age <= w_aged_idx;
                end
                if (!o_sts.last) r_idx <= r_idx + 1'b1;
            end
            if (i_ctl.finish) begin
                o_forked_pid <= '0;
                o_status <= pas_pkg::ST_OK;
                unique case (r_cmd)
                    pas_pkg::CMD_TICK: begin
                        r_cur <= r_best;
                    end
                    pas_pkg::CMD_FORK: begin
                        if (w_any_free) begin
                            r_base[w_free] <= r_base[r_cur];
                            r_par[w_free]  <= r_cur;
                            r_aged[w_free] <= w_fp;
                            r_run[w_free]  <= 1'b1;
                            r_asg[w_free]  <= 1'b1;
                            o_forked_pid   <= 4'(w_free);
                        end else begin
                            o_status <= pas_pkg::ST_FULL;
                        end
                    end
                    pas_pkg::CMD_EXEC: begin
                        r_base[r_cur] <= r_newp;
                        r_aged[r_cur] <= AGE_WIDTH'(r_newp);
                    end
                    pas_pkg::CMD_EXIT: begin
                        if (!r_fail) begin
                            r_run[r_cur] <= 1'b0;
                            r_cur <= '0;
                        end
                    end
                    pas_pkg::CMD_KILL: begin
                        if (w_tgt_ok) r_run[w_tgt_idx] <= 1'b0;
                        else o_status <= pas_pkg::ST_NOT_FOUND;
                    end
                    pas_pkg::CMD_KILL_ALL: begin
                        r_run <= r_run & SLOTS'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // current and parent follow table state
    assign o_active_pid = 4'(r_cur);
    assign o_parent_pid = 4'(r_par[r_cur]);
endmodule
`default_nettype wire

// File: rtl/pas_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_ctrl
// Command sequencer: aging pass and selection pass for tick, handshakes.
// ----------------------------------------------------------------------------
module pas_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  wire            i_stall,
    input  wire [2:0]      i_cmd,
    output pas_pkg::t_ctl  o_ctl,
    input  pas_pkg::t_sts  i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_AGE  = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_tick, n_tick;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_tick  = r_tick;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_ctl.start = 1'b1;
                n_tick = (i_cmd == pas_pkg::CMD_TICK);
                n_state = S_DEC;
            end
            S_DEC:  n_state = r_tick ? S_AGE : S_FIN;
            S_AGE: begin
                o_ctl.age = 1'b1;
                if (i_sts.last) n_state = S_PICK;
            end
            S_PICK: begin
                o_ctl.pick = 1'b1;
                if (i_sts.last) n_state = S_FIN;
            end
            S_FIN: begin
                o_ctl.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
        end
    end
endmodule
`default_nettype wire

// File: rtl/priority_aging_process_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_aging_process_scheduler
// Tick: one aging walk, then one selection walk over the slot table;
// other commands skip both walks. One request at a time.
// Synchronous active-low reset restores slot 0 as the only running slot.
// ----------------------------------------------------------------------------
module priority_aging_process_scheduler #(
    parameter int SLOTS     = 16,
    parameter int AGE_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_data,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [2:0]  i_cmd,
    input  wire [3:0]  i_target_pid,
    input  wire [7:0]  i_new_priority,
    input  wire        i_exit_failed,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [3:0] o_active_pid,
    output logic [3:0] o_parent_pid,
    output logic [3:0] o_forked_pid,
    output logic [1:0] o_status
);
    pas_pkg::t_ctl w_ctl;
    pas_pkg::t_sts w_sts;

    pas_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_cmd(i_cmd),
        .o_ctl(w_ctl), .i_sts(w_sts)
    );

    pas_datapath #(.SLOTS(SLOTS), .AGE_WIDTH(AGE_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .o_sts(w_sts),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_cmd(i_cmd),
        .i_target_pid(i_target_pid), .i_new_priority(i_new_priority),
        .i_exit_failed(i_exit_failed), .o_active_pid(o_active_pid),
        .o_parent_pid(o_parent_pid), .o_forked_pid(o_forked_pid),
        .o_status(o_status)
    );
endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the priority aging scheduler against an in-bench model of its slot
// table, with directed commands, random command mixes and random stalls.
// ----------------------------------------------------------------------------
module testbench;
    localparam int SLOTS      = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] target;
        logic [7:0] newp;
        logic       failed;
    } t_request;

    typedef struct packed {
        logic [3:0] cur;
        logic [3:0] parent;
        logic [3:0] forked;
        logic [1:0] status;
    } t_answer;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        out_stall = 1'b0;
    t_request    req_drv = '0;
    wire         in_stall;
    wire         out_valid;
    wire [3:0]   cur_pid, par_pid, frk_pid;
    wire [1:0]   status;

    priority_aging_process_scheduler uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall), .i_cmd(req_drv.cmd),
        .i_target_pid(req_drv.target), .i_new_priority(req_drv.newp),
        .i_exit_failed(req_drv.failed), .o_valid(out_valid), .i_stall(out_stall),
        .o_active_pid(cur_pid), .o_parent_pid(par_pid), .o_forked_pid(frk_pid),
        .o_status(status)
    );

    always #2 clk = ~clk;

    // scheduler model
    logic        sch_running [SLOTS];
    logic        sch_assigned[SLOTS];
    logic [7:0]  sch_base    [SLOTS];
    logic [15:0] sch_aged    [SLOTS];
    logic [3:0]  sch_parent  [SLOTS];
    logic [3:0]  sch_cur;
    logic [15:0] sch_fork_prio;

    t_request pending_q[$];
    t_answer  answer_q[$];
    int  errors = 0;
    int  accepted = 0;
    int  answered = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  done = 1'b0;
    bit  in_fire = 1'b0;

    function automatic logic [15:0] sat_add(logic [15:0] a, logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, a} + b;
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < SLOTS; i++) begin
            sch_running[i] = 1'b0; sch_assigned[i] = 1'b0;
            sch_base[i] = '0; sch_aged[i] = '0; sch_parent[i] = '0;
        end
        sch_running[0] = 1'b1;
        sch_base[0] = pas_pkg::IDLE_PRIORITY;
        sch_aged[0] = 16'(pas_pkg::IDLE_PRIORITY);
        sch_cur = '0;
        sch_fork_prio = pas_pkg::FORK_PRIORITY_RESET;
    endfunction

    function automatic t_answer sched_apply(t_request r);
        t_answer a;
        logic [15:0] top;
        logic [3:0] pick;
        a = '0;
        a.status = pas_pkg::ST_OK;
        case (r.cmd)
            pas_pkg::CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++)
                    if (i != sch_cur && sch_running[i])
                        sch_aged[i] = sat_add(sch_aged[i], sch_base[i]);
                sch_aged[sch_cur] = 16'(sch_base[sch_cur]);
                top = '0; pick = '0;
                for (int i = 0; i < SLOTS; i++)
                    if (sch_running[i] && sch_aged[i] > top) begin
                        top = sch_aged[i]; pick = 4'(i);
                    end
                sch_cur = pick;
            end
            pas_pkg::CMD_FORK: begin
                a.status = pas_pkg::ST_FULL;
                for (int i = 0; i < SLOTS; i++)
                    if (!sch_running[i]) begin
                        sch_base[i] = sch_base[sch_cur];
                        sch_parent[i] = sch_cur;
                        sch_aged[i] = sch_fork_prio;
                        sch_running[i] = 1'b1;
                        sch_assigned[i] = 1'b1;
                        a.forked = 4'(i);
                        a.status = pas_pkg::ST_OK;
                        break;
                    end
            end
            pas_pkg::CMD_EXEC: begin
                sch_base[sch_cur] = r.newp;
                sch_aged[sch_cur] = 16'(r.newp);
            end
            pas_pkg::CMD_EXIT: begin
                if (!r.failed) begin
                    sch_running[sch_cur] = 1'b0;
                    sch_cur = '0;
                end
            end
            pas_pkg::CMD_KILL: begin
                if (r.target == 0 || sch_assigned[r.target])
                    sch_running[r.target] = 1'b0;
                else
                    a.status = pas_pkg::ST_NOT_FOUND;
            end
            pas_pkg::CMD_KILL_ALL: begin
                for (int i = 1; i < SLOTS; i++) sch_running[i] = 1'b0;
            end
            default: ;
        endcase
        a.cur = sch_cur;
        a.parent = sch_parent[sch_cur];
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on answer %0d: %s got %0d want %0d", answered, what, got, want);
        errors++;
    endtask

    function automatic t_request make_request(logic [2:0] c, logic [3:0] t = '0,
                                              logic [7:0] p = '0, logic f = 1'b0);
        t_request r;
        r.cmd = c; r.target = t; r.newp = p; r.failed = f;
        return r;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int w;
        r.target = 4'($urandom);
        r.newp = 8'($urandom);
        r.failed = 1'($urandom_range(0, 3) == 0);
        w = $urandom_range(0, 99);
        if (w < 40) r.cmd = pas_pkg::CMD_TICK;
        else if (w < 62) r.cmd = pas_pkg::CMD_FORK;
        else if (w < 74) r.cmd = pas_pkg::CMD_EXEC;
        else if (w < 84) r.cmd = pas_pkg::CMD_EXIT;
        else if (w < 95) r.cmd = pas_pkg::CMD_KILL;
        else if (w < 98) r.cmd = pas_pkg::CMD_KILL_ALL;
        else r.cmd = ($urandom_range(0, 1) == 0) ? CMD_RSVD_A : CMD_RSVD_B;
        return r;
    endfunction

    // driver
    always @(negedge clk) begin
        if (rst_n && !(in_valid && !in_fire)) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
                req_drv <= pending_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= !calm && $urandom_range(0, 99) < 25;
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n) begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                answer_q.push_back(sched_apply(req_drv));
                accepted++;
            end
            if (out_valid && !out_stall) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected answer", 1, 0);
                end else begin
                    t_answer w;
                    w = answer_q.pop_front();
                    if (cur_pid !== w.cur) report_mismatch("active_pid", cur_pid, w.cur);
                    if (par_pid !== w.parent) report_mismatch("parent_pid", par_pid, w.parent);
                    if (frk_pid !== w.forked) report_mismatch("forked_pid", frk_pid, w.forked);
                    if (status !== w.status) report_mismatch("status", status, w.status);
                end
                answered++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (!done && idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d answers outstanding", answer_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic drain();
        wait (pending_q.size() == 0 && !in_valid && answer_q.size() == 0);
        repeat (2 * SLOTS + 8) @(posedge clk);
    endtask

    task automatic write_fork_priority(logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sch_fork_prio = v;
    endtask

    initial begin
        sched_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        pending_q.push_back(make_request(pas_pkg::CMD_TICK));
        pending_q.push_back(make_request(pas_pkg::CMD_KILL, 4'd0));
        pending_q.push_back(make_request(pas_pkg::CMD_TICK));
        pending_q.push_back(make_request(pas_pkg::CMD_KILL, 4'd15));
        pending_q.push_back(make_request(pas_pkg::CMD_FORK));
        pending_q.push_back(make_request(pas_pkg::CMD_EXEC, 4'd0, 8'd255));
        pending_q.push_back(make_request(pas_pkg::CMD_TICK));
        pending_q.push_back(make_request(pas_pkg::CMD_EXIT, 4'd0, 8'd0, 1'b1));
        pending_q.push_back(make_request(pas_pkg::CMD_EXIT));
        for (int i = 0; i < SLOTS; i++) pending_q.push_back(make_request(pas_pkg::CMD_FORK));
        pending_q.push_back(make_request(pas_pkg::CMD_KILL, 4'd15));
        pending_q.push_back(make_request(pas_pkg::CMD_KILL_ALL));
        pending_q.push_back(make_request(CMD_RSVD_A));
        pending_q.push_back(make_request(CMD_RSVD_B, 4'hF, 8'hFF, 1'b1));
        drain();

        write_fork_priority(16'hFFFF);
        calm = 1'b1;
        for (int i = 0; i < 400; i++) pending_q.push_back(random_request());
        drain();
        calm = 1'b0;
        write_fork_priority(16'h0000);
        for (int i = 0; i < 500; i++) pending_q.push_back(random_request());
        drain();
        write_fork_priority(16'(pas_pkg::FORK_PRIORITY_RESET));
        for (int i = 0; i < 500; i++) pending_q.push_back(random_request());
        drain();
        write_fork_priority(16'($urandom));
        for (int i = 0; i < 600; i++) pending_q.push_back(random_request());
        drain();

        done = 1'b1;
        $display("%0d commands sent, %0d answers checked, four fork priority settings",
                 accepted, answered);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: priority_aging_process_scheduler.f
rtl/pas_pkg.sv
rtl/pas_datapath.sv
rtl/pas_ctrl.sv
rtl/priority_aging_process_scheduler.sv
verif/testbench.sv
